/* rtl/pidtc_pkg.sv */
// Package for the PID turn controller: field widths, register map, reset values,
// stage payload types and fixed-point constants.
// No dependencies.
package pidtc_pkg;

   // field widths
   localparam int TURN_W     = 13;
   localparam int MEAS_W     = 21;
   localparam int ERR_W      = 22;
   localparam int DERIV_W    = ERR_W + 1;
   localparam int INTEG_W    = 32;
   localparam int SUM_W      = 32;
   localparam int GAIN_W     = 20;
   localparam int LIMIT_W    = 12;
   localparam int ZONE_W     = 16;
   localparam int ITER_W     = 16;
   localparam int DRIVE_W    = 13;
   localparam int ANGLE_FRAC = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   // heading arithmetic
   localparam int DEG_PER_REV  = 360;
   localparam int DEG_W        = 9;
   localparam int TGT_W        = 10;
   localparam longint WRAP_RESIDUE = (longint'(1) << SUM_W) % DEG_PER_REV;
   localparam int RED_W        = 14;
   localparam int RED_OFFSET   = 13 * DEG_PER_REV;
   localparam int RECIP_SHIFT  = 19;
   localparam int RECIP_MUL    = (1 << RECIP_SHIFT) / DEG_PER_REV;
   localparam int RECIP_W      = 11;
   localparam int QUOT_W       = RED_W + RECIP_W - RECIP_SHIFT;

   // control law
   localparam int PROD_P_W    = ERR_W + GAIN_W;
   localparam int PROD_D_W    = DERIV_W + GAIN_W;
   localparam int PROD_I_W    = INTEG_W + GAIN_W;
   localparam int ACC_W       = PROD_I_W + 2;
   localparam int DRIVE_SHIFT = 12;
   localparam int SHIFTED_W   = ACC_W - DRIVE_SHIFT;

   localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
   localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

   localparam logic CMD_START  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P      = 3'd0,
      CSR_GAIN_I      = 3'd1,
      CSR_GAIN_D      = 3'd2,
      CSR_DRIVE_LIMIT = 3'd3,
      CSR_INTEG_ZONE  = 3'd4,
      CSR_SETTLE_TOL  = 3'd5,
      CSR_ITER_LIMIT  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  gain_p;
      logic [GAIN_W-1:0]  gain_i;
      logic [GAIN_W-1:0]  gain_d;
      logic [LIMIT_W-1:0] drive_limit;
      logic [ZONE_W-1:0]  integral_zone;
      logic [ZONE_W-1:0]  settle_tolerance;
      logic [ITER_W-1:0]  iteration_limit;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      gain_p:           20'd12452,
      gain_i:           20'd655,
      gain_d:           20'd6554,
      drive_limit:      12'd1536,
      integral_zone:    16'd256,
      settle_tolerance: 16'd8,
      iteration_limit:  16'd300
   };

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_RUN   = 2'd1,
      KIND_END   = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type                   kind;
      logic signed [ERR_W-1:0]    err;
      logic signed [DERIV_W-1:0]  deriv;
      logic signed [INTEG_W-1:0]  integ;
      logic [ITER_W-1:0]          iters;
   } law_in_type;

   typedef struct packed {
      logic load_mul;
      logic load_out;
   } law_ctl_type;

endpackage

/* rtl/pidtc_csr.sv */
// Configuration registers of the PID turn controller.
// Depends on pidtc_pkg for the register map and reset values.
module pidtc_csr import pidtc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_GAIN_P:      cfg_in.gain_p           = csr_data[GAIN_W-1:0];
            CSR_GAIN_I:      cfg_in.gain_i           = csr_data[GAIN_W-1:0];
            CSR_GAIN_D:      cfg_in.gain_d           = csr_data[GAIN_W-1:0];
            CSR_DRIVE_LIMIT: cfg_in.drive_limit      = csr_data[LIMIT_W-1:0];
            CSR_INTEG_ZONE:  cfg_in.integral_zone    = csr_data[ZONE_W-1:0];
            CSR_SETTLE_TOL:  cfg_in.settle_tolerance = csr_data[ZONE_W-1:0];
            CSR_ITER_LIMIT:  cfg_in.iteration_limit  = csr_data[ITER_W-1:0];
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/pidtc_track.sv */
// Turn state of the PID turn controller: heading target, error history,
// integral and iteration count, updated once per item.
// Depends on pidtc_pkg for widths, constants and stage types.
module pidtc_track import pidtc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,
   input  cfg_type                   cfg,
   input  logic                      cmd,
   input  logic signed [TURN_W-1:0]  turn_angle,
   input  logic signed [MEAS_W-1:0]  measured_angle,
   output law_in_type                law_in
);

   logic [SUM_W-1:0]          angle_sum_ff, angle_sum_in;
   logic [DEG_W-1:0]          heading_mod_ff, heading_mod_in;
   logic signed [TGT_W-1:0]   target_ff, target_in;
   logic signed [ERR_W-1:0]   last_error_ff, last_error_in;
   logic signed [INTEG_W-1:0] integral_ff, integral_in;
   logic [ITER_W-1:0]         count_ff, count_in;
   logic                      active_ff, active_in;

   logic [SUM_W-1:0]               turn_ext;
   logic [SUM_W-1:0]               sum_next;
   logic                           wrap_up, wrap_dn;
   logic signed [RED_W-1:0]        red_x, wrap_adj;
   logic [RED_W-1:0]               red_y, rem_raw;
   logic [RED_W+RECIP_W-1:0]       recip_prod;
   logic [QUOT_W-1:0]              quot_est;
   logic [DEG_W-1:0]               mod_new;
   logic signed [TGT_W-1:0]        target_new;

   logic signed [ERR_W-1:0]   err;
   logic [ERR_W-1:0]          mag;
   logic                      run_ok, in_zone;
   logic signed [DERIV_W-1:0] deriv;
   logic signed [INTEG_W:0]   integ_sum;
   logic signed [INTEG_W-1:0] integ_sat, integ_new;
   logic [ITER_W-1:0]         count_inc;

   // heading: keep the floor residue of the running sum by 360 alongside it
   always_comb begin
      turn_ext = {{(SUM_W-TURN_W){turn_angle[TURN_W-1]}}, turn_angle};
      sum_next = angle_sum_ff + turn_ext;
      wrap_up  = !angle_sum_ff[SUM_W-1] && !turn_angle[TURN_W-1] && sum_next[SUM_W-1];
      wrap_dn  = angle_sum_ff[SUM_W-1] && turn_angle[TURN_W-1] && !sum_next[SUM_W-1];
      // a signed wrap of the sum moves it by 2^32, which is WRAP_RESIDUE mod 360
      wrap_adj = '0;
      if (wrap_up) begin
         wrap_adj = -RED_W'(WRAP_RESIDUE);
      end else if (wrap_dn) begin
         wrap_adj = RED_W'(WRAP_RESIDUE);
      end
      red_x = $signed({{(RED_W-DEG_W){1'b0}}, heading_mod_ff})
            + $signed({{(RED_W-TURN_W){turn_angle[TURN_W-1]}}, turn_angle})
            + wrap_adj;
      red_y = $unsigned(red_x) + RED_W'(RED_OFFSET);
      // quotient by reciprocal, low by at most one
      recip_prod = (RED_W+RECIP_W)'(red_y) * (RED_W+RECIP_W)'(RECIP_MUL);
      quot_est   = recip_prod[RECIP_SHIFT +: QUOT_W];
      rem_raw    = red_y - RED_W'(RED_W'(quot_est) * RED_W'(DEG_PER_REV));
      if (rem_raw >= RED_W'(DEG_PER_REV)) begin
         mod_new = DEG_W'(rem_raw - RED_W'(DEG_PER_REV));
      end else begin
         mod_new = DEG_W'(rem_raw);
      end
      // truncating remainder takes the sign of the sum
      if (sum_next[SUM_W-1] && (mod_new != '0)) begin
         target_new = $signed({1'b0, mod_new}) - $signed(TGT_W'(DEG_PER_REV));
      end else begin
         target_new = $signed({1'b0, mod_new});
      end
   end

   // sample: error, settle test, derivative and integral
   always_comb begin
      err = $signed({{(ERR_W-TGT_W-ANGLE_FRAC){target_ff[TGT_W-1]}}, target_ff,
                     {ANGLE_FRAC{1'b0}}})
          - $signed({{(ERR_W-MEAS_W){measured_angle[MEAS_W-1]}}, measured_angle});
      mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
      run_ok = active_ff && (mag > ERR_W'(cfg.settle_tolerance))
            && (count_ff < cfg.iteration_limit);
      deriv = $signed({err[ERR_W-1], err}) - $signed({last_error_ff[ERR_W-1], last_error_ff});
      in_zone   = (err != '0) && (mag < ERR_W'(cfg.integral_zone));
      integ_sum = $signed({integral_ff[INTEG_W-1], integral_ff})
                + $signed({{(INTEG_W+1-ERR_W){err[ERR_W-1]}}, err});
      if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
         integ_sat = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
      end else begin
         integ_sat = integ_sum[INTEG_W-1:0];
      end
      integ_new = in_zone ? integ_sat : '0;
      count_inc = count_ff + ITER_W'(1);
   end

   always_comb begin
      law_in         = '0;
      law_in.kind    = KIND_START;
      angle_sum_in   = angle_sum_ff;
      heading_mod_in = heading_mod_ff;
      target_in      = target_ff;
      last_error_in  = last_error_ff;
      integral_in    = integral_ff;
      count_in       = count_ff;
      active_in      = active_ff;
      if (cmd == CMD_START) begin
         angle_sum_in   = sum_next;
         heading_mod_in = mod_new;
         target_in      = target_new;
         last_error_in  = '0;
         integral_in    = '0;
         count_in       = '0;
         active_in      = 1'b1;
      end else if (run_ok) begin
         law_in.kind   = KIND_RUN;
         law_in.err    = err;
         law_in.deriv  = deriv;
         law_in.integ  = integ_new;
         law_in.iters  = count_inc;
         last_error_in = err;
         integral_in   = integ_new;
         count_in      = count_inc;
      end else begin
         law_in.kind  = KIND_END;
         law_in.err   = err;
         law_in.iters = count_ff;
         active_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_sum_ff   <= '0;
         heading_mod_ff <= '0;
         target_ff      <= '0;
         last_error_ff  <= '0;
         integral_ff    <= '0;
         count_ff       <= '0;
         active_ff      <= 1'b0;
      end else if (fire) begin
         angle_sum_ff   <= angle_sum_in;
         heading_mod_ff <= heading_mod_in;
         target_ff      <= target_in;
         last_error_ff  <= last_error_in;
         integral_ff    <= integral_in;
         count_ff       <= count_in;
         active_ff      <= active_in;
      end
   end

endmodule

/* rtl/pidtc_law.sv */
// Control law of the PID turn controller: gain products, sum, shift and clamp,
// ending in the result register.
// Depends on pidtc_pkg for widths and stage types.
module pidtc_law import pidtc_pkg::*; (
   input  logic                       clock,
   input  law_ctl_type                ctl,
   input  cfg_type                    cfg,
   input  law_in_type                 law_in,
   output logic signed [DRIVE_W-1:0]  drive,
   output logic                       done_res,
   output logic signed [ERR_W-1:0]    error,
   output logic [ITER_W-1:0]          iterations
);

   kind_type                   kind_ff;
   logic signed [ERR_W-1:0]    err_ff;
   logic [ITER_W-1:0]          iters_ff;
   logic signed [PROD_P_W-1:0] prod_p_ff, prod_p_in;
   logic signed [PROD_D_W-1:0] prod_d_ff, prod_d_in;
   logic signed [PROD_I_W-1:0] prod_i_ff, prod_i_in;

   logic signed [DRIVE_W-1:0]  drive_ff, drive_in;
   logic                       done_ff;
   logic signed [ERR_W-1:0]    error_ff;
   logic [ITER_W-1:0]          iterations_ff;

   logic signed [ACC_W-1:0]     acc;
   logic signed [SHIFTED_W-1:0] shifted, lim, neg_lim, clamped;

   always_comb begin
      prod_p_in = $signed(law_in.err)   * $signed({1'b0, cfg.gain_p});
      prod_d_in = $signed(law_in.deriv) * $signed({1'b0, cfg.gain_d});
      prod_i_in = $signed(law_in.integ) * $signed({1'b0, cfg.gain_i});
   end

   always_comb begin
      acc = ACC_W'(prod_p_ff) + ACC_W'(prod_d_ff) + ACC_W'(prod_i_ff);
      // floor division by 4096
      shifted = acc[ACC_W-1:DRIVE_SHIFT];
      lim     = $signed({{(SHIFTED_W-LIMIT_W){1'b0}}, cfg.drive_limit});
      neg_lim = -lim;
      if (shifted > lim) begin
         clamped = lim;
      end else if (shifted < neg_lim) begin
         clamped = neg_lim;
      end else begin
         clamped = shifted;
      end
      drive_in = (kind_ff == KIND_RUN) ? clamped[DRIVE_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (ctl.load_mul) begin
         kind_ff   <= law_in.kind;
         err_ff    <= law_in.err;
         iters_ff  <= law_in.iters;
         prod_p_ff <= prod_p_in;
         prod_d_ff <= prod_d_in;
         prod_i_ff <= prod_i_in;
      end
      if (ctl.load_out) begin
         drive_ff      <= drive_in;
         done_ff       <= (kind_ff == KIND_END);
         error_ff      <= err_ff;
         iterations_ff <= iters_ff;
      end
   end

   assign drive      = drive_ff;
   assign done_res   = done_ff;
   assign error      = error_ff;
   assign iterations = iterations_ff;

endmodule

/* rtl/pid_turn_controller_unit.sv */
// Top level of the PID turn controller: channel handshakes, item pipeline
// and instances of pidtc_csr, pidtc_track and pidtc_law (types from pidtc_pkg).
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    cmd, turn_angle, measured_angle
//   rsp      out        rsp_valid/stall    drive, done_res, error, iterations
//   csr      in         csr_valid/ready    index, data (register write)
//
// One item per cycle sustained while rsp_stall is low; each result passes the input,
// stage, product and result registers. The per-item state update (target, last error,
// integral, count) is combinational between the input and stage registers.
// Synchronous reset restores register defaults and an idle turn; no clearing pass.
// Each stage holds while the one after it is full and held; a stalled result
// still lets the stages behind it fill.
module pid_turn_controller_unit import pidtc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_cmd,
   input  logic signed [TURN_W-1:0]  req_turn_angle,
   input  logic signed [MEAS_W-1:0]  req_measured_angle,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [DRIVE_W-1:0] rsp_drive,
   output logic                      rsp_done_res,
   output logic signed [ERR_W-1:0]   rsp_error,
   output logic [ITER_W-1:0]         rsp_iterations,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data
);

   cfg_type     cfg;
   law_in_type  law_in;
   law_in_type  law_in_ff;
   law_ctl_type law_ctl;

   logic                     cmd_ff;
   logic signed [TURN_W-1:0] turn_ff;
   logic signed [MEAS_W-1:0] meas_ff;

   logic in_valid_ff, in_valid_in;
   logic st_valid_ff, st_valid_in;
   logic mul_valid_ff, mul_valid_in;
   logic out_valid_ff, out_valid_in;
   logic in_open, st_open, mul_open, out_open;
   logic fire;

   // a stage takes a beat when it is empty or its content moves on
   always_comb begin
      out_open = !out_valid_ff || !rsp_stall;
      mul_open = !mul_valid_ff || out_open;
      st_open  = !st_valid_ff || mul_open;
      in_open  = !in_valid_ff || st_open;
      fire     = in_valid_ff && st_open;

      in_valid_in  = in_open  ? req_valid    : in_valid_ff;
      st_valid_in  = st_open  ? in_valid_ff  : st_valid_ff;
      mul_valid_in = mul_open ? st_valid_ff  : mul_valid_ff;
      out_valid_in = out_open ? mul_valid_ff : out_valid_ff;

      law_ctl.load_mul = mul_open;
      law_ctl.load_out = out_open;
   end

   assign req_stall = !in_open;
   assign rsp_valid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         st_valid_ff  <= 1'b0;
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         st_valid_ff  <= st_valid_in;
         mul_valid_ff <= mul_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_open) begin
         cmd_ff  <= req_cmd;
         turn_ff <= req_turn_angle;
         meas_ff <= req_measured_angle;
      end
      if (st_open) begin
         law_in_ff <= law_in;
      end
   end

   pidtc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pidtc_track u_track (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .cfg            (cfg),
      .cmd            (cmd_ff),
      .turn_angle     (turn_ff),
      .measured_angle (meas_ff),
      .law_in         (law_in)
   );

   pidtc_law u_law (
      .clock      (clock),
      .ctl        (law_ctl),
      .cfg        (cfg),
      .law_in     (law_in_ff),
      .drive      (rsp_drive),
      .done_res   (rsp_done_res),
      .error      (rsp_error),
      .iterations (rsp_iterations)
   );

endmodule

/* test/pidtc_tb_pkg.sv */
// Heading tracker for the PID turn controller bench: predicts each result beat
// and matches the beats that come out. Depends on pidtc_pkg for widths and codes.
`timescale 1ns / 100ps
package pidtc_tb_pkg;
   import pidtc_pkg::*;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic                      done_res;
      logic signed [ERR_W-1:0]   error;
      logic [ITER_W-1:0]         iterations;
   } heading_result_type;

   class heading_tracker;
      cfg_type            setting;
      bit [SUM_W-1:0]     angle_sum;
      int                 target_deg;
      longint             last_err;
      longint             integ;
      logic [ITER_W-1:0]  iter_count;
      bit                 active;
      heading_result_type awaited_results[$];
      int                 mismatches;
      int                 shown;

      function new();
         setting = CFG_RESET;
         angle_sum = '0;
         target_deg = 0;
         last_err = 0;
         integ = 0;
         iter_count = '0;
         active = 1'b0;
         mismatches = 0;
         shown = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_GAIN_P:      setting.gain_p = data;
            CSR_GAIN_I:      setting.gain_i = data;
            CSR_GAIN_D:      setting.gain_d = data;
            CSR_DRIVE_LIMIT: setting.drive_limit = data[LIMIT_W-1:0];
            CSR_INTEG_ZONE:  setting.integral_zone = data[ZONE_W-1:0];
            CSR_SETTLE_TOL:  setting.settle_tolerance = data[ZONE_W-1:0];
            CSR_ITER_LIMIT:  setting.iteration_limit = data[ITER_W-1:0];
            default: ;
         endcase
      endfunction

      function int sum_now();
         int s;
         s = $signed(angle_sum);
         return s;
      endfunction

      // Advance the heading state by one accepted input beat and queue its result.
      function void take_item(logic cmd, logic signed [TURN_W-1:0] turn,
                              logic signed [MEAS_W-1:0] meas);
         heading_result_type r;
         longint err, mag, deriv, acc, drv, lim;
         r = '0;
         r.done_res = 1'b1;
         if (cmd == CMD_START) begin
            angle_sum = angle_sum + 32'(turn);
            target_deg = sum_now() % DEG_PER_REV;
            last_err = 0;
            integ = 0;
            iter_count = '0;
            active = 1'b1;
            r.done_res = 1'b0;
         end else begin
            err = longint'(target_deg) * 16 - longint'(meas);
            mag = (err < 0) ? -err : err;
            if (active && mag > longint'(setting.settle_tolerance) &&
                iter_count < setting.iteration_limit) begin
               iter_count = iter_count + 1'b1;
               deriv = err - last_err;
               last_err = err;
               if (err != 0 && mag < longint'(setting.integral_zone)) begin
                  integ = integ + err;
                  if (integ > 64'sd2147483647) integ = 64'sd2147483647;
                  if (integ < -64'sd2147483648) integ = -64'sd2147483648;
               end else begin
                  integ = 0;
               end
               acc = err * longint'(setting.gain_p) + deriv * longint'(setting.gain_d) +
                     integ * longint'(setting.gain_i);
               drv = acc >>> DRIVE_SHIFT;
               lim = longint'(setting.drive_limit);
               if (drv > lim) drv = lim;
               if (drv < -lim) drv = -lim;
               r.drive = DRIVE_W'(drv);
               r.done_res = 1'b0;
            end else begin
               active = 1'b0;
            end
            r.error = ERR_W'(err);
            r.iterations = iter_count;
         end
         awaited_results.push_back(r);
      endfunction

      function void match_result(heading_result_type got);
         heading_result_type want;
         if (awaited_results.size() == 0) begin
            mismatches++;
            if (shown < 10) begin
               shown++;
               $display("unexpected result beat: drive %0d done %0d error %0d iterations %0d",
                        got.drive, got.done_res, got.error, got.iterations);
            end
            return;
         end
         want = awaited_results.pop_front();
         if (got.drive !== want.drive || got.done_res !== want.done_res ||
             got.error !== want.error || got.iterations !== want.iterations) begin
            mismatches++;
            if (shown < 10) begin
               shown++;
               $display("mismatch: drive %0d/%0d done %0d/%0d error %0d/%0d iter %0d/%0d (exp/got)",
                        want.drive, got.drive, want.done_res, got.done_res,
                        want.error, got.error, want.iterations, got.iterations);
            end
         end
      endfunction

      function int pending();
         return awaited_results.size();
      endfunction

      function bit clean();
         return mismatches == 0 && awaited_results.size() == 0;
      endfunction
   endclass

endpackage

/* test/tb_top.sv */
// Bench top for pid_turn_controller_unit: drives turns, gyro samples and register
// writes under varied pacing and checks every result beat. Needs pidtc_pkg, pidtc_tb_pkg.
`timescale 1ns / 100ps
module tb_top;
   import pidtc_pkg::*;
   import pidtc_tb_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 160;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   typedef enum int {PACE_STEADY, PACE_SENDER_GAPS, PACE_RECEIVER_STALLS, PACE_BOTH} pace_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_cmd = CMD_SAMPLE;
   logic signed [TURN_W-1:0]  req_turn_angle = '0;
   logic signed [MEAS_W-1:0]  req_measured_angle = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [DRIVE_W-1:0] rsp_drive;
   logic                      rsp_done_res;
   logic signed [ERR_W-1:0]   rsp_error;
   logic [ITER_W-1:0]         rsp_iterations;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_data = '0;

   heading_tracker     book = new();
   heading_result_type seen;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_asks = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int cycles = 0;

   pid_turn_controller_unit DUT (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off whenever one is asked for.
   always @(posedge clock) begin
      if (hold_asks != hold_seen) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.drive = rsp_drive;
         seen.done_res = rsp_done_res;
         seen.error = rsp_error;
         seen.iterations = rsp_iterations;
         book.match_result(seen);
      end
   end

   function automatic int noise_angle();
      return int'($urandom_range(2097151)) - 1048576;
   endfunction

   function automatic int random_turn();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) begin
         case ($urandom_range(4))
            0: return -3600;
            1: return 3600;
            2: return -1;
            3: return 1;
            default: return 0;
         endcase
      end
      if (pick < 3) return int'($urandom_range(7200)) - 3600;
      return int'($urandom_range(360)) - 180;
   endfunction

   function automatic int random_error();
      int pick;
      pick = $urandom_range(99);
      if (pick < 20) return int'($urandom_range(20)) - 10;
      if (pick < 50) return int'($urandom_range(600)) - 300;
      if (pick < 80) return int'($urandom_range(10000)) - 5000;
      return int'($urandom_range(140000)) - 70000;
   endfunction

   task automatic set_pace(input pace_type pace);
      case (pace)
         PACE_STEADY:          begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         PACE_SENDER_GAPS:     begin send_idle_pct = 47; recv_stall_pct = 0;  end
         PACE_RECEIVER_STALLS: begin send_idle_pct = 0;  recv_stall_pct = 47; end
         default:              begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
   endtask

   // Hold the payload until the beat is taken; valid stays high for the next beat.
   task automatic send_item(input logic cmd, input logic signed [TURN_W-1:0] turn,
                            input logic signed [MEAS_W-1:0] meas);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_turn_angle <= turn;
      req_measured_angle <= meas;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book.take_item(cmd, turn, meas);
   endtask

   task automatic send_start(input int turn);
      send_item(CMD_START, TURN_W'(turn), MEAS_W'(noise_angle()));
   endtask

   task automatic send_sample(input int meas);
      send_item(CMD_SAMPLE, TURN_W'(int'($urandom_range(7200)) - 3600), MEAS_W'(meas));
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      book.write_reg(idx, data);
   endtask

   task automatic load_setting(input cfg_type c);
      write_csr(CSR_GAIN_P, c.gain_p);
      write_csr(CSR_GAIN_I, c.gain_i);
      write_csr(CSR_GAIN_D, c.gain_d);
      write_csr(CSR_DRIVE_LIMIT, CSR_DATA_W'(c.drive_limit));
      write_csr(CSR_INTEG_ZONE, CSR_DATA_W'(c.integral_zone));
      write_csr(CSR_SETTLE_TOL, CSR_DATA_W'(c.settle_tolerance));
      write_csr(CSR_ITER_LIMIT, CSR_DATA_W'(c.iteration_limit));
      csr_valid <= 1'b0;
   endtask

   // Drain: drop valid, wait for every result, then let the pipeline go quiet.
   task automatic settle();
      req_valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic cfg_type pick_setting(input int which);
      cfg_type c;
      c = CFG_RESET;
      case (which)
         0: ;
         1: c = '{20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 12'hFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
         2: c = '0;
         3: begin
            c.gain_p = GAIN_W'($urandom_range(20000));
            c.gain_i = GAIN_W'($urandom_range(2000));
            c.gain_d = GAIN_W'($urandom_range(20000));
            c.drive_limit = 12'd3072;
            c.integral_zone = 16'hFFFF;
            c.settle_tolerance = '0;
            c.iteration_limit = 16'hFFFF;
         end
         default: begin
            if ($urandom_range(1)) begin
               c.gain_p = GAIN_W'($urandom_range(1048575));
               c.gain_i = GAIN_W'($urandom_range(1048575));
               c.gain_d = GAIN_W'($urandom_range(1048575));
            end else begin
               c.gain_p = GAIN_W'($urandom_range(30000));
               c.gain_i = GAIN_W'($urandom_range(3000));
               c.gain_d = GAIN_W'($urandom_range(30000));
            end
            c.drive_limit = LIMIT_W'($urandom_range(4095));
            c.integral_zone = ZONE_W'($urandom_range(1) ? $urandom_range(1000)
                                                         : $urandom_range(65535));
            c.settle_tolerance = ZONE_W'($urandom_range(40));
            case ($urandom_range(2))
               0: c.iteration_limit = ITER_W'($urandom_range(40));
               1: c.iteration_limit = 16'd300;
               default: c.iteration_limit = 16'hFFFF;
            endcase
         end
      endcase
      return c;
   endfunction

   // Mostly whole turns whose error shrinks toward settling; the rest is noise samples and bare starts.
   task automatic run_turns(input int quota);
      int sent, pick, len, e;
      sent = 0;
      while (sent < quota) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            send_start(random_turn());
            sent++;
            len = $urandom_range(1, 24);
            e = random_error();
            repeat (len) begin
               send_sample(book.target_deg * 16 - e);
               sent++;
               e = e * int'($urandom_range(30, 95)) / 100 + int'($urandom_range(6)) - 3;
            end
         end else if (pick < 90) begin
            send_sample(noise_angle());
            sent++;
         end else begin
            send_start(random_turn());
            sent++;
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // samples while idle, then turns that hit clamps, zone, tolerance and exact target
      send_sample(0);
      send_sample(-1048576);
      send_sample(1048575);
      send_start(-1);
      send_sample(0);
      send_sample(-16);
      send_sample(5);
      send_start(3600);
      send_sample(0);
      send_sample(1048575);
      send_sample(-1048576);
      send_sample(5744 - 100);
      send_sample(5744 - 40);
      send_sample(5744 + 8);
      send_start(-3600);
      send_start(0);
      send_sample(-16 + 300);
      send_sample(-16 - 255);
      send_start(721);
      send_sample(0);
      settle();

      for (int p = 0; p < PHASES; p++) begin
         if (p == 5) write_csr(CSR_SPARE, CSR_DATA_W'($urandom));
         load_setting(pick_setting(p));
         set_pace(pace_type'(p % 4));
         if (p == 4) hold_asks = hold_asks + 1;
         run_turns(PHASE_ITEMS);
         settle();
      end

      if (book.clean()) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/pidtc_pkg.sv
rtl/pidtc_csr.sv
rtl/pidtc_track.sv
rtl/pidtc_law.sv
rtl/pid_turn_controller_unit.sv
test/pidtc_tb_pkg.sv
test/tb_top.sv
